// ===== hdl/srf_pkg.sv =====
// shared types and codes for the searchable record fifo
`timescale 1ns / 1ps

package srf_pkg;

   // default number of records held
   localparam int DEPTH_DEFAULT = 128;

   // operation codes
   localparam logic [1:0] FUNC_ENQUEUE = 2'd0;
   localparam logic [1:0] FUNC_DEQUEUE = 2'd1;
   localparam logic [1:0] FUNC_SEARCH  = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   // one stored record
   typedef struct packed {
      logic [63:0] name;
      logic [63:0] career;
      logic [7:0]  subjects;
      logic [9:0]  average;
   } record_type;

endpackage

// ===== hdl/srf_store.sv =====
// record storage ram, one write port and one registered read port
`timescale 1ns / 1ps

module srf_store #(
   parameter int DEPTH = srf_pkg::DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  srf_pkg::record_type        wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output srf_pkg::record_type        rd_data
);

   srf_pkg::record_type mem [DEPTH];
   srf_pkg::record_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/searchable_record_fifo_unit.sv =====
// searchable record fifo: circular record store with a one-entry-per-cycle search walk
//
//   channel  direction  signals
//   req      in         req_valid, req_ready, req_func, req_name_key, req_career_key,
//                       req_subjects, req_average
//   rsp      out        rsp_valid, rsp_ready, rsp_status, rsp_position, rsp_name_out,
//                       rsp_career_out, rsp_subjects_out, rsp_average_out, rsp_occupancy
//
// enqueue, no-op and failed operations post their result on acceptance; a dequeue posts
// it after one ram read. a search compares the name key against each entry: the
// single ram read port is walked one entry per cycle from the head.
// reset empties the queue at once; ram contents are left as they are.
// req_ready is low while an item is in progress and while a result is held
// unless that result is taken in the same cycle.
`timescale 1ns / 1ps

module searchable_record_fifo_unit #(
   parameter int DEPTH = srf_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [63:0] req_name_key,
   input  logic [63:0] req_career_key,
   input  logic [7:0]  req_subjects,
   input  logic [9:0]  req_average,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_position,
   output logic [63:0] rsp_name_out,
   output logic [63:0] rsp_career_out,
   output logic [7:0]  rsp_subjects_out,
   output logic [9:0]  rsp_average_out,
   output logic [7:0]  rsp_occupancy
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_ADDR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_DEQUEUE = 2'd1;
   localparam logic [1:0] S_SEARCH  = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] walk_ff, walk_in;
   logic [CW-1:0] issue_ff, issue_in;
   logic          cmp_valid_ff, cmp_valid_in;
   logic [PW-1:0] cmp_idx_ff, cmp_idx_in;
   logic [63:0]   key_ff, key_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          status_ff;
   logic [6:0]          position_ff;
   srf_pkg::record_type rec_out_ff;

   logic                post_en;
   logic [1:0]          post_status;
   logic [6:0]          post_position;
   srf_pkg::record_type post_rec;

   logic                wr_en;
   srf_pkg::record_type wr_data;
   logic                rd_en;
   logic [PW-1:0]       rd_addr;
   srf_pkg::record_type rd_data;
   logic                accept;

   // circular pointer step
   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      logic [PW-1:0] r;
      if (p == LAST_ADDR) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   srf_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign wr_data.name     = req_name_key;
   assign wr_data.career   = req_career_key;
   assign wr_data.subjects = req_subjects;
   assign wr_data.average  = req_average;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      walk_in       = walk_ff;
      issue_in      = issue_ff;
      cmp_valid_in  = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      key_in        = key_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = walk_ff;
      post_en       = 1'b0;
      post_status   = srf_pkg::STATUS_OK;
      post_position = '0;
      post_rec      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_func)
                  srf_pkg::FUNC_ENQUEUE: begin
                     post_en = 1'b1;
                     if (count_ff == FULL_COUNT) begin
                        post_status = srf_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        tail_in  = ptr_next(tail_ff);
                        count_in = count_ff + 1'b1;
                     end
                  end
                  srf_pkg::FUNC_DEQUEUE: begin
                     if (count_ff == '0) begin
                        post_en     = 1'b1;
                        post_status = srf_pkg::STATUS_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        state_in = S_DEQUEUE;
                     end
                  end
                  srf_pkg::FUNC_SEARCH: begin
                     if (count_ff == '0) begin
                        post_en     = 1'b1;
                        post_status = srf_pkg::STATUS_NOT_FOUND;
                     end else begin
                        // first read goes out with the transfer
                        rd_en        = 1'b1;
                        rd_addr      = head_ff;
                        walk_in      = ptr_next(head_ff);
                        issue_in     = CW'(1);
                        cmp_valid_in = 1'b1;
                        cmp_idx_in   = '0;
                        key_in       = req_name_key;
                        state_in     = S_SEARCH;
                     end
                  end
                  default: begin
                     post_en = 1'b1;
                  end
               endcase
            end
         end
         S_DEQUEUE: begin
            post_en  = 1'b1;
            post_rec = rd_data;
            head_in  = ptr_next(head_ff);
            count_in = count_ff - 1'b1;
            state_in = S_IDLE;
         end
         S_SEARCH: begin
            // compare the entry read last cycle
            if (cmp_valid_ff && (rd_data.name == key_ff)) begin
               post_en       = 1'b1;
               post_position = 7'(cmp_idx_ff);
               state_in      = S_IDLE;
            end else if (cmp_valid_ff && ((CW'(cmp_idx_ff) + 1'b1) == count_ff)) begin
               post_en     = 1'b1;
               post_status = srf_pkg::STATUS_NOT_FOUND;
               state_in    = S_IDLE;
            end else begin
               if (cmp_valid_ff) begin
                  cmp_idx_in = cmp_idx_ff + 1'b1;
               end
               // keep one read in flight ahead of the compare
               if (issue_ff != count_ff) begin
                  rd_en        = 1'b1;
                  walk_in      = ptr_next(walk_ff);
                  issue_in     = issue_ff + 1'b1;
                  cmp_valid_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = post_en || (rsp_valid_ff && !rsp_ready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // walk and payload registers
   always_ff @(posedge clock) begin
      walk_ff    <= walk_in;
      issue_ff   <= issue_in;
      cmp_idx_ff <= cmp_idx_in;
      key_ff     <= key_in;
      if (post_en) begin
         status_ff   <= post_status;
         position_ff <= post_position;
         rec_out_ff  <= post_rec;
      end
   end

   // result outputs
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_position     = position_ff;
   assign rsp_name_out     = rec_out_ff.name;
   assign rsp_career_out   = rec_out_ff.career;
   assign rsp_subjects_out = rec_out_ff.subjects;
   assign rsp_average_out  = rec_out_ff.average;
   assign rsp_occupancy    = 8'(count_ff);

endmodule

// ===== bench/searchable_record_fifo_checker.sv =====
// checker for the searchable record fifo: predicts each response and compares it on transfer
`timescale 1ns / 1ps

module searchable_record_fifo_checker #(
   parameter int DEPTH = srf_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [63:0] req_name_key,
   input  logic [63:0] req_career_key,
   input  logic [7:0]  req_subjects,
   input  logic [9:0]  req_average,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic [6:0]  rsp_position,
   input  logic [63:0] rsp_name_out,
   input  logic [63:0] rsp_career_out,
   input  logic [7:0]  rsp_subjects_out,
   input  logic [9:0]  rsp_average_out,
   input  logic [7:0]  rsp_occupancy,
   output int          failures,
   output int          pending
);

   // one predicted response
   typedef struct packed {
      logic [1:0]  status;
      logic [6:0]  position;
      logic [63:0] name;
      logic [63:0] career;
      logic [7:0]  subjects;
      logic [9:0]  average;
      logic [7:0]  occupancy;
   } response_type;

   // records the queue should hold, head first
   srf_pkg::record_type queued_records[$];
   // responses still owed by the block, oldest first
   response_type        owed_responses[$];

   // apply one request to the predicted queue and build its response
   function automatic response_type apply_request(input logic [1:0] func,
                                                  input srf_pkg::record_type rec);
      response_type        resp;
      srf_pkg::record_type head;
      int                  idx;
      logic                found;
      resp        = '0;
      resp.status = srf_pkg::STATUS_OK;
      found       = 1'b0;
      case (func)
         srf_pkg::FUNC_ENQUEUE: begin
            if (queued_records.size() >= DEPTH) resp.status = srf_pkg::STATUS_FULL;
            else queued_records.push_back(rec);
         end
         srf_pkg::FUNC_DEQUEUE: begin
            if (queued_records.size() == 0) begin
               resp.status = srf_pkg::STATUS_EMPTY;
            end else begin
               head          = queued_records.pop_front();
               resp.name     = head.name;
               resp.career   = head.career;
               resp.subjects = head.subjects;
               resp.average  = head.average;
            end
         end
         srf_pkg::FUNC_SEARCH: begin
            // first match from the head wins
            resp.status = srf_pkg::STATUS_NOT_FOUND;
            for (idx = 0; idx < queued_records.size(); idx++) begin
               if (!found && queued_records[idx].name == rec.name) begin
                  found         = 1'b1;
                  resp.status   = srf_pkg::STATUS_OK;
                  resp.position = idx[6:0];
               end
            end
         end
         default: ;
      endcase
      idx            = queued_records.size();
      resp.occupancy = idx[7:0];
      return resp;
   endfunction

   // print one mismatch line and count it
   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      failures = failures + 1;
   endtask

   // compare responses first, then record the new request of the same edge
   always @(posedge clock) begin
      response_type        want;
      srf_pkg::record_type rec;
      if (reset) begin
         queued_records.delete();
         owed_responses.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_responses.size() == 0) begin
               report_mismatch("response transfer with no request waiting");
            end else begin
               want = owed_responses.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_status, want.status));
               if (rsp_position !== want.position)
                  report_mismatch($sformatf("position got %0d want %0d",
                                            rsp_position, want.position));
               if (rsp_name_out !== want.name)
                  report_mismatch($sformatf("name_out got %h want %h",
                                            rsp_name_out, want.name));
               if (rsp_career_out !== want.career)
                  report_mismatch($sformatf("career_out got %h want %h",
                                            rsp_career_out, want.career));
               if (rsp_subjects_out !== want.subjects)
                  report_mismatch($sformatf("subjects_out got %0d want %0d",
                                            rsp_subjects_out, want.subjects));
               if (rsp_average_out !== want.average)
                  report_mismatch($sformatf("average_out got %0d want %0d",
                                            rsp_average_out, want.average));
               if (rsp_occupancy !== want.occupancy)
                  report_mismatch($sformatf("occupancy got %0d want %0d",
                                            rsp_occupancy, want.occupancy));
            end
         end
         if (req_valid && req_ready) begin
            rec.name     = req_name_key;
            rec.career   = req_career_key;
            rec.subjects = req_subjects;
            rec.average  = req_average;
            owed_responses.push_back(apply_request(req_func, rec));
         end
      end
      pending = owed_responses.size();
   end

endmodule

// ===== bench/searchable_record_fifo_unit_test.sv =====
// testbench top for the searchable record fifo: stimulus, idling, watchdog and verdict
`timescale 1ns / 1ps

module searchable_record_fifo_unit_test;

   // code the block treats as a no-op
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam int HOLD_OFF_CYCLES = 400;
   localparam int IDLE_LIMIT      = 4000;
   localparam int END_CYCLES      = 300;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func       = srf_pkg::FUNC_ENQUEUE;
   logic [63:0] req_name_key   = '0;
   logic [63:0] req_career_key = '0;
   logic [7:0]  req_subjects   = '0;
   logic [9:0]  req_average    = '0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [1:0]  rsp_status;
   logic [6:0]  rsp_position;
   logic [63:0] rsp_name_out;
   logic [63:0] rsp_career_out;
   logic [7:0]  rsp_subjects_out;
   logic [9:0]  rsp_average_out;
   logic [7:0]  rsp_occupancy;

   int          failures;
   int          pending;
   int          send_idle_pct    = 0;
   int          recv_stall_pct   = 0;
   logic        hold_off_request = 1'b0;
   int          idle_cycles      = 0;
   logic [63:0] name_pool [16];

   searchable_record_fifo_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_name_key     (req_name_key),
      .req_career_key   (req_career_key),
      .req_subjects     (req_subjects),
      .req_average      (req_average),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_position     (rsp_position),
      .rsp_name_out     (rsp_name_out),
      .rsp_career_out   (rsp_career_out),
      .rsp_subjects_out (rsp_subjects_out),
      .rsp_average_out  (rsp_average_out),
      .rsp_occupancy    (rsp_occupancy)
   );

   searchable_record_fifo_checker #(
      .DEPTH (srf_pkg::DEPTH_DEFAULT)
   ) i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_name_key     (req_name_key),
      .req_career_key   (req_career_key),
      .req_subjects     (req_subjects),
      .req_average      (req_average),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_position     (rsp_position),
      .rsp_name_out     (rsp_name_out),
      .rsp_career_out   (rsp_career_out),
      .rsp_subjects_out (rsp_subjects_out),
      .rsp_average_out  (rsp_average_out),
      .rsp_occupancy    (rsp_occupancy),
      .failures         (failures),
      .pending          (pending)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver: random stalls, or one long hold-off when asked
   always begin
      @(negedge clock);
      if (hold_off_request) begin
         rsp_ready <= 1'b0;
         repeat (HOLD_OFF_CYCLES) @(negedge clock);
         hold_off_request = 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   function automatic logic [63:0] rand_word64();
      return {$urandom, $urandom};
   endfunction

   // mostly pooled names so that searches hit and duplicates occur
   function automatic logic [63:0] pick_name();
      if ($urandom_range(99) < 70) return name_pool[4'($urandom_range(15))];
      return rand_word64();
   endfunction

   function automatic logic [63:0] pick_career();
      int roll;
      roll = $urandom_range(99);
      if (roll < 5) return '0;
      if (roll < 10) return '1;
      return rand_word64();
   endfunction

   // mostly legal averages, some above 1000
   function automatic logic [9:0] pick_average();
      if ($urandom_range(99) < 8) return 10'($urandom_range(1023, 1001));
      return 10'($urandom_range(1000));
   endfunction

   // offer one request, with random idle cycles first, and wait for its transfer
   task automatic send_item(input logic [1:0] func, input logic [63:0] name,
                            input logic [63:0] career, input logic [7:0] subjects,
                            input logic [9:0] average);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_name_key   <= name;
      req_career_key <= career;
      req_subjects   <= subjects;
      req_average    <= average;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // stop offering and wait for every owed response
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   // random requests with the given enqueue and dequeue shares, a 2% share of the unused code, rest searches
   task automatic send_random(input int count, input int enq_pct, input int deq_pct);
      int         n;
      int         roll;
      logic [1:0] func;
      for (n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 2) func = FUNC_UNUSED;
         else if (roll < 2 + enq_pct) func = srf_pkg::FUNC_ENQUEUE;
         else if (roll < 2 + enq_pct + deq_pct) func = srf_pkg::FUNC_DEQUEUE;
         else func = srf_pkg::FUNC_SEARCH;
         send_item(func, pick_name(), pick_career(), 8'($urandom_range(255)),
                   pick_average());
      end
   endtask

   initial begin
      int          n;
      logic [63:0] key_a;
      logic [63:0] key_b;
      name_pool[0] = '0;
      name_pool[1] = '1;
      for (n = 2; n < 16; n++) name_pool[4'(n)] = rand_word64();
      key_a = name_pool[2];
      key_b = name_pool[3];

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty queue cases
      send_item(srf_pkg::FUNC_DEQUEUE, '0, '0, '0, '0);
      send_item(srf_pkg::FUNC_SEARCH, '0, '0, '0, '0);
      send_item(FUNC_UNUSED, '1, '1, '1, '1);
      // directed: field extremes, out-of-range average, duplicate name
      send_item(srf_pkg::FUNC_ENQUEUE, '0, '0, 8'd0, 10'd0);
      send_item(srf_pkg::FUNC_ENQUEUE, '1, '1, 8'd255, 10'd1023);
      send_item(srf_pkg::FUNC_ENQUEUE, key_a, rand_word64(), 8'd128, 10'd1000);
      send_item(srf_pkg::FUNC_ENQUEUE, '0, rand_word64(), 8'd17, 10'd1001);
      // directed: hits at several positions, miss, no-op on a partly filled queue
      send_item(srf_pkg::FUNC_SEARCH, '0, '0, '0, '0);
      send_item(srf_pkg::FUNC_SEARCH, '1, '0, '0, '0);
      send_item(srf_pkg::FUNC_SEARCH, key_a, '0, '0, '0);
      send_item(srf_pkg::FUNC_SEARCH, rand_word64(), '0, '0, '0);
      send_item(FUNC_UNUSED, key_a, '0, '0, '0);
      send_item(srf_pkg::FUNC_DEQUEUE, '0, '0, '0, '0);
      // duplicate is found further down once the head is gone
      send_item(srf_pkg::FUNC_SEARCH, '0, '0, '0, '0);
      for (n = 0; n < 4; n++) send_item(srf_pkg::FUNC_DEQUEUE, '1, '1, '1, '1);
      send_item(srf_pkg::FUNC_ENQUEUE, key_a, rand_word64(), 8'd1, 10'd500);
      send_item(srf_pkg::FUNC_ENQUEUE, key_b, rand_word64(), 8'd2, 10'd999);
      send_item(srf_pkg::FUNC_SEARCH, key_b, '0, '0, '0);
      send_item(srf_pkg::FUNC_DEQUEUE, '0, '0, '0, '0);
      send_item(srf_pkg::FUNC_DEQUEUE, '0, '0, '0, '0);

      // receiver holds off while the sender keeps offering
      hold_off_request = 1'b1;
      send_random(8, 60, 20);
      wait_drained();

      // no idling: fill past full, then drain past empty
      send_random(180, 80, 5);
      wait_drained();
      send_random(180, 5, 80);
      wait_drained();

      // sender idle
      send_idle_pct  = 77;
      recv_stall_pct = 0;
      send_random(120, 40, 35);
      wait_drained();

      // receiver stalling
      send_idle_pct  = 0;
      recv_stall_pct = 77;
      send_random(120, 40, 35);
      wait_drained();

      // both idling
      send_idle_pct  = 25;
      recv_stall_pct = 25;
      send_random(120, 40, 35);
      wait_drained();

      repeat (END_CYCLES) @(negedge clock);
      if (failures == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
